// ===== src/tlnef_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_pkg
// Shared types and character codes for the text line number / escape filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

    // character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CARET_OFS = 8'd64;
    localparam logic [7:0] CTRL_TOP  = 8'd31;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_ends;
        logic       show_tabs;
        logic       show_nonprinting;
    } tlnef_cfg_t;

    // line tracking state carried from one byte to the next
    typedef struct packed {
        logic after_nl;
        logic blank_seen;
    } tlnef_line_t;

endpackage : tlnef_pkg
`default_nettype wire

// ===== src/text_line_number_escape_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_number_escape_filter
// Line numbering, blank squeezing and escape rendering for a byte stream.
// ----------------------------------------------------------------------------
// Each accepted byte is rendered in the cycle it is taken and loaded into a
// shift buffer of NUMBER_DIGITS+3 bytes that drives the master side directly.
// An input byte renders one output byte when plain, two for an escape or a
// marked line end, and up to NUMBER_DIGITS+3 at a numbered line start. The
// next byte is taken in the same cycle the last byte of the previous one is
// taken downstream, so plain text streams at one byte per cycle while the
// receiver does not stall. A squeezed newline is taken and gives no output.
// m_tlast flags the final output byte of each input byte. Configuration must
// be written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [tlnef_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tlnef_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  wire logic                            s_tuser,   // [0] file_start
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] out_byte
    output logic                                 m_tlast    // last_of_run
);
    import tlnef_pkg::*;

    localparam int DEPTH = NUMBER_DIGITS + 3;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlnef_cfg_t  cfg_reg;
    tlnef_cfg_t  cfg_next;
    tlnef_line_t line_reg;
    tlnef_line_t line_next;

    logic                          accept;
    logic                          count_step;
    logic [4*NUMBER_DIGITS-1:0]    count_bcd;
    logic [DEPTH-1:0][7:0]         r_bytes;
    logic [CNT_W-1:0]              r_cnt;

    assign accept = s_tvalid & s_tready;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NUMBER_MODE:      cfg_next.number_mode      = cfg_wdata;
                REG_SQUEEZE_BLANK:    cfg_next.squeeze_blank    = cfg_wdata[0];
                REG_SHOW_ENDS:        cfg_next.show_ends        = cfg_wdata[0];
                REG_SHOW_TABS:        cfg_next.show_tabs        = cfg_wdata[0];
                REG_SHOW_NONPRINTING: cfg_next.show_nonprinting = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg             <= '0;
            line_reg.after_nl   <= 1'b1;
            line_reg.blank_seen <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
            if (accept) begin
                line_reg <= line_next;
            end
        end
    end

    tlnef_bcd_counter #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_counter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (accept & s_tuser),
        .step    (accept & count_step),
        .count_o (count_bcd)
    );

    tlnef_render #(
        .NUMBER_DIGITS(NUMBER_DIGITS),
        .DEPTH        (DEPTH),
        .CNT_W        (CNT_W)
    ) u_render (
        .data_byte  (s_tdata),
        .file_start (s_tuser),
        .cfg        (cfg_reg),
        .line_cur   (line_reg),
        .count_bcd  (count_bcd),
        .line_next  (line_next),
        .count_step (count_step),
        .bytes      (r_bytes),
        .n_bytes    (r_cnt)
    );

    tlnef_out_buf #(
        .DEPTH(DEPTH),
        .CNT_W(CNT_W)
    ) u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .load_bytes (r_bytes),
        .load_cnt   (r_cnt),
        .load_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTH
    // input side never blocks while the output is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output buffer");

    // a request that renders bytes shows up on the output next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && r_cnt != '0) |=> m_tvalid)
        else $error("rendered request produced no output");

    // a dropped newline leaves the filter inside a blank run
    a_squeeze_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && r_cnt == '0) |=> (line_reg.after_nl && line_reg.blank_seen))
        else $error("squeezed newline lost line state");

    // the low count digit stays a valid BCD digit
    a_bcd_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(accept) |-> (count_bcd[3:0] <= 4'd9))
        else $error("line counter digit out of BCD range");
`endif

endmodule : text_line_number_escape_filter
`default_nettype wire

// ===== src/tlnef_bcd_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_bcd_counter
// Saturating BCD line counter; clears to one at a file start.
// ----------------------------------------------------------------------------
module tlnef_bcd_counter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       clear,
    input  wire logic                       step,
    output logic [4*NUMBER_DIGITS-1:0]      count_o
);
    localparam int W = 4 * NUMBER_DIGITS;
    localparam logic [W-1:0] BCD_ONE = W'(1);

    logic [W-1:0] count_reg;
    logic [W-1:0] count_next;
    logic [W-1:0] count_inc;

    // value seen by the current request (file start restarts at one)
    assign count_o = clear ? BCD_ONE : count_reg;

    always_comb begin
        logic       all_nine;
        logic       carry;
        logic [3:0] d;
        all_nine  = 1'b1;
        carry     = 1'b1;
        count_inc = count_o;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            d = count_o[4*i +: 4];
            if (d != 4'd9) all_nine = 1'b0;
            if (carry) begin
                if (d >= 4'd9) begin
                    count_inc[4*i +: 4] = 4'd0;
                end else begin
                    count_inc[4*i +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nine) count_inc = count_o;
    end

    always_comb begin
        count_next = count_reg;
        if (step) begin
            count_next = count_inc;
        end else if (clear) begin
            count_next = BCD_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= BCD_ONE;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule : tlnef_bcd_counter
`default_nettype wire

// ===== src/tlnef_render.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_render
// Renders one input byte into its list of output bytes and next line state.
// ----------------------------------------------------------------------------
module tlnef_render #(
    parameter int NUMBER_DIGITS = 6,
    parameter int DEPTH         = NUMBER_DIGITS + 3,
    parameter int CNT_W         = $clog2(DEPTH + 1)
) (
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       file_start,
    input  wire tlnef_pkg::tlnef_cfg_t      cfg,
    input  wire tlnef_pkg::tlnef_line_t     line_cur,
    input  wire logic [4*NUMBER_DIGITS-1:0] count_bcd,
    output tlnef_pkg::tlnef_line_t          line_next,
    output logic                            count_step,
    output logic [DEPTH-1:0][7:0]           bytes,
    output logic [CNT_W-1:0]                n_bytes
);
    import tlnef_pkg::*;

    localparam logic [CNT_W-1:0] PREFIX_LEN = CNT_W'(NUMBER_DIGITS + 1);

    logic       after_nl;
    logic       blank;
    logic       is_nl;
    logic       is_tab;
    logic       drop;
    logic       numbering;
    logic       has_pre;
    logic [7:0] pre_byte;
    logic [7:0] ch_tab;
    logic [7:0] ch_out;
    logic [7:0] tail0;
    logic [NUMBER_DIGITS-1:0][7:0] digit_chars;

    assign after_nl = file_start | line_cur.after_nl;
    assign blank    = ~file_start & line_cur.blank_seen;
    assign is_nl    = (data_byte == CH_NL);
    assign is_tab   = (data_byte == CH_TAB);

    // squeezed newline: produces nothing
    assign drop = cfg.squeeze_blank & is_nl & after_nl & blank;

    always_comb begin
        if (cfg.number_mode[1]) begin
            numbering = after_nl & ~is_nl;
        end else if (cfg.number_mode[0]) begin
            numbering = after_nl;
        end else begin
            numbering = 1'b0;
        end
        numbering = numbering & ~drop;
    end

    assign count_step          = numbering;
    assign line_next.after_nl   = is_nl;
    assign line_next.blank_seen = cfg.squeeze_blank ? (is_nl & after_nl) : blank;

    // escapes: at most one marker byte ahead of the byte itself
    always_comb begin
        has_pre  = 1'b0;
        pre_byte = CH_CARET;
        ch_tab   = data_byte;
        ch_out   = data_byte;
        if (cfg.show_ends && is_nl) begin
            has_pre  = 1'b1;
            pre_byte = CH_DOLLAR;
        end
        if (cfg.show_tabs && is_tab) begin
            has_pre = 1'b1;
            ch_tab  = CH_I;
        end
        ch_out = ch_tab;
        if (cfg.show_nonprinting) begin
            if (ch_tab <= CTRL_TOP && ch_tab != CH_TAB && ch_tab != CH_NL) begin
                has_pre = 1'b1;
                ch_out  = ch_tab + CARET_OFS;
            end else if (ch_tab == CH_DEL) begin
                has_pre = 1'b1;
                ch_out  = ch_tab - CARET_OFS;
            end
        end
    end

    assign tail0 = has_pre ? pre_byte : ch_out;

    // number prefix, leading zeros shown as spaces
    always_comb begin
        logic       seen_nz;
        logic [3:0] d;
        seen_nz = 1'b0;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            d = count_bcd[4*(NUMBER_DIGITS-1-i) +: 4];
            if (d != 4'd0 || i == NUMBER_DIGITS - 1) seen_nz = 1'b1;
            digit_chars[i] = seen_nz ? (CH_ZERO + {4'd0, d}) : CH_SPACE;
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (numbering) begin
                if (i < NUMBER_DIGITS) begin
                    bytes[i] = digit_chars[i];
                end else if (i == NUMBER_DIGITS) begin
                    bytes[i] = CH_TAB;
                end else if (i == NUMBER_DIGITS + 1) begin
                    bytes[i] = tail0;
                end else begin
                    bytes[i] = ch_out;
                end
            end else begin
                if (i == 0) begin
                    bytes[i] = tail0;
                end else if (i == 1) begin
                    bytes[i] = ch_out;
                end else begin
                    bytes[i] = 8'd0;
                end
            end
        end
    end

    always_comb begin
        if (drop) begin
            n_bytes = '0;
        end else begin
            n_bytes = (numbering ? PREFIX_LEN : CNT_W'(0))
                    + CNT_W'(has_pre) + CNT_W'(1);
        end
    end

endmodule : tlnef_render
`default_nettype wire

// ===== src/tlnef_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlnef_out_buf
// Output shift buffer: loads byte lists, sends one byte per cycle on m_tready.
// ----------------------------------------------------------------------------
module tlnef_out_buf #(
    parameter int DEPTH = 9,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire logic [DEPTH-1:0][7:0] load_bytes,
    input  wire logic [CNT_W-1:0]     load_cnt,
    output logic                      load_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,
    output logic                      m_tlast
);
    logic [DEPTH-1:0][7:0] buf_reg;
    logic [DEPTH-1:0][7:0] buf_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  pop;

    assign m_tvalid   = (cnt_reg != '0);
    assign m_tlast    = (cnt_reg == CNT_W'(1));
    assign m_tdata    = buf_reg[0];
    assign pop        = m_tvalid & m_tready;
    // free once the last byte of the previous request leaves
    assign load_ready = ~m_tvalid | (m_tlast & m_tready);

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = load_bytes;
            cnt_next = load_cnt;
        end else if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule : tlnef_out_buf
`default_nettype wire

// ===== bench/text_line_number_escape_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_number_escape_filter_tb
// Self-checking bench for the line number / escape filter.
// ----------------------------------------------------------------------------
// A directed table walks every option, the caret escapes, the numbering modes
// and blank squeezing, then random text lines run under a series of register
// settings, plus a numbered stretch that carries the counter into its third
// digit. Every rendered byte is checked against the typed text of its table
// row or a local model of the filter. The sender idles in bursts and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter_tb;
    import tlnef_pkg::*;

    localparam int DIGITS       = 6;
    localparam int SETTLE       = DIGITS + 6;
    localparam int STUCK_LIMIT  = 2000;
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 30;
    localparam int COUNT_LINES  = 120;

    localparam logic [4*DIGITS-1:0] LINE_ONE = (4*DIGITS)'(1);

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_SHOW_NONPRINTING + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    // {number_mode, squeeze_blank, show_ends, show_tabs, show_nonprinting}
    localparam tlnef_cfg_t CFG_PLAIN      = '{2'd0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam tlnef_cfg_t CFG_CARET      = '{2'd0, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam tlnef_cfg_t CFG_CARET_TABS = '{2'd0, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam tlnef_cfg_t CFG_ENDS       = '{2'd0, 1'b0, 1'b1, 1'b0, 1'b0};
    localparam tlnef_cfg_t CFG_NUM_ALL    = '{2'd1, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam tlnef_cfg_t CFG_NUM_TEXT   = '{2'd2, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam tlnef_cfg_t CFG_NUM_BOTH   = '{2'd3, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam tlnef_cfg_t CFG_SQUEEZE    = '{2'd1, 1'b1, 1'b0, 1'b0, 1'b0};
    localparam tlnef_cfg_t CFG_ALL_ON     = '{2'd3, 1'b1, 1'b1, 1'b1, 1'b1};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_byte_t;

    // exp_len == 0: rely on the model, else exp_text holds the bytes, first char leftmost
    typedef struct packed {
        tlnef_cfg_t  cfg;
        logic [7:0]  raw;
        logic        new_file;
        logic [3:0]  exp_len;
        logic [71:0] exp_text;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;

    // model state
    tlnef_cfg_t              active_cfg;
    logic                    at_line_start;
    logic                    blank_pending;
    logic [4*DIGITS-1:0]     line_no;
    logic [7:0]              fresh_q [$];
    out_byte_t               rendered_q [$];

    dir_row_t    dir_table [NUM_DIRECTED];
    out_byte_t   want;
    int unsigned burst_left = 0;
    int unsigned error_count = 0;
    int unsigned requests_in = 0;
    int unsigned bytes_out = 0;
    int unsigned settings_used = 0;
    int unsigned stuck = 0;
    logic [4*DIGITS-1:0] peak_line_no = '0;
    logic [15:0] stall_pat = '1;
    int unsigned pat_age = 0;

    always #6 aclk = ~aclk;

    text_line_number_escape_filter #(
        .NUMBER_DIGITS(DIGITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Renders one byte into fresh_q and advances the line state.
    function automatic void render_byte(input logic [7:0] raw, input logic new_file);
        logic [7:0] ch;
        logic       numbered;
        logic       leading;
        logic       carry;
        logic [3:0] digit;
        int         i;
        fresh_q.delete();
        ch = raw;
        if (new_file) begin
            at_line_start = 1'b1;
            blank_pending = 1'b0;
            line_no       = LINE_ONE;
        end
        if (active_cfg.squeeze_blank) begin
            if (ch == CH_NL && at_line_start) begin
                if (blank_pending)
                    return;     // dropped, line start stays set
                blank_pending = 1'b1;
            end else begin
                blank_pending = 1'b0;
            end
        end
        // non-empty mode wins when both bits are set
        if (active_cfg.number_mode[1])
            numbered = at_line_start && ch != CH_NL;
        else
            numbered = at_line_start && active_cfg.number_mode[0];
        if (numbered) begin
            leading = 1'b1;
            for (i = DIGITS - 1; i >= 0; i--) begin
                digit = line_no[4*i +: 4];
                if (digit != 4'd0 || i == 0)
                    leading = 1'b0;
                fresh_q.push_back(leading ? CH_SPACE : CH_ZERO + {4'd0, digit});
            end
            fresh_q.push_back(CH_TAB);
            if (line_no != {DIGITS{4'h9}}) begin
                carry = 1'b1;
                for (i = 0; i < DIGITS; i++) begin
                    if (carry) begin
                        if (line_no[4*i +: 4] >= 4'd9) begin
                            line_no[4*i +: 4] = 4'd0;
                        end else begin
                            line_no[4*i +: 4] = line_no[4*i +: 4] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
            end
            if (line_no > peak_line_no)
                peak_line_no = line_no;
        end
        at_line_start = (ch == CH_NL);
        if (active_cfg.show_ends && ch == CH_NL)
            fresh_q.push_back(CH_DOLLAR);
        if (active_cfg.show_tabs && ch == CH_TAB) begin
            fresh_q.push_back(CH_CARET);
            ch = CH_I;
        end
        if (active_cfg.show_nonprinting) begin
            if (ch <= CTRL_TOP && ch != CH_TAB && ch != CH_NL) begin
                fresh_q.push_back(CH_CARET);
                ch = ch + CARET_OFS;
            end else if (ch == CH_DEL) begin
                fresh_q.push_back(CH_CARET);
                ch = ch - CARET_OFS;
            end
        end
        fresh_q.push_back(ch);
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6: return 8'($urandom_range(32, 126));
            7, 8:                return CH_TAB;
            9:                   return 8'($urandom_range(0, 31));
            10:                  return CH_DEL;
            11:                  return 8'($urandom_range(128, 254));
            12:                  return 8'hFF;
            default:             return 8'($urandom);
        endcase
    endfunction

    function automatic void flag_error(input string what, input out_byte_t exp_b,
                                       input logic [7:0] got_ch, input logic got_last);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s: expected %02h last %0b, got %02h last %0b",
                     $realtime, what, exp_b.ch, exp_b.last, got_ch, got_last);
    endfunction

    // One request on the input side, with burst gaps, then its expected bytes.
    task automatic send_request(input logic [7:0] raw, input logic new_file,
                                input int unsigned typed_len, input logic [71:0] typed_text);
        int unsigned gap;
        int unsigned k;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tuser  <= new_file;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        requests_in++;
        render_byte(raw, new_file);
        if (typed_len != 0) begin
            for (k = 0; k < typed_len; k++)
                rendered_q.push_back('{typed_text[8*(typed_len-1-k) +: 8],
                                       k == typed_len - 1});
        end else begin
            for (k = 0; k < fresh_q.size(); k++)
                rendered_q.push_back('{fresh_q[k], k == fresh_q.size() - 1});
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (rendered_q.size() != 0)
            @(posedge aclk);
        // a squeezed newline leaves nothing to wait for, so give it time
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_settings(input tlnef_cfg_t c);
        logic [CFG_IDX_W-1:0]  idx  [6];
        logic [CFG_DATA_W-1:0] data [6];
        int i;
        wait_drained();
        // stray write outside the register map must be ignored
        idx[0]  = CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED));
        data[0] = CFG_DATA_W'($urandom);
        idx[1]  = REG_NUMBER_MODE;
        data[1] = c.number_mode;
        idx[2]  = REG_SQUEEZE_BLANK;
        data[2] = {1'($urandom), c.squeeze_blank};
        idx[3]  = REG_SHOW_ENDS;
        data[3] = {1'($urandom), c.show_ends};
        idx[4]  = REG_SHOW_TABS;
        data[4] = {1'($urandom), c.show_tabs};
        idx[5]  = REG_SHOW_NONPRINTING;
        data[5] = {1'($urandom), c.show_nonprinting};
        for (i = 0; i < 6; i++) begin
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= data[i];
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        active_cfg = c;
        settings_used++;
    endtask

    // receiver stall pattern, reloaded now and then
    always @(negedge aclk) begin
        if (pat_age == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat = '1;
                1: stall_pat = 16'($urandom);
                2: stall_pat = 16'($urandom) | 16'($urandom);
                default: stall_pat = ~(16'h1 << $urandom_range(0, 15));
            endcase
            stall_pat[0] = 1'b1;
            pat_age = $urandom_range(16, 200);
        end
        pat_age--;
        m_tready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            bytes_out++;
            if (rendered_q.size() == 0) begin
                flag_error("output with nothing pending", '0, m_tdata, m_tlast);
            end else begin
                want = rendered_q.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.last)
                    flag_error("output mismatch", want, m_tdata, m_tlast);
            end
        end
    end

    initial begin
        while (stuck < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no handshake for %0d cycles", $realtime, STUCK_LIMIT);
        $display("[text_line_number_escape_filter] ERROR");
        $finish;
    end

    initial begin
        tlnef_cfg_t  next_cfg;
        int unsigned phase;
        int unsigned sent;
        int unsigned len;
        int unsigned n;
        int          r;
        logic        mid_drained;

        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b1;
        active_cfg    = '0;
        at_line_start = 1'b1;
        blank_pending = 1'b0;
        line_no       = LINE_ONE;
        mid_drained   = 1'b0;

        dir_table[0]  = '{CFG_PLAIN,      "A",     1'b1, 4'd1, "A"};
        dir_table[1]  = '{CFG_PLAIN,      8'hFF,   1'b0, 4'd1, 72'hFF};
        dir_table[2]  = '{CFG_PLAIN,      8'h00,   1'b0, 4'd1, 72'h00};
        dir_table[3]  = '{CFG_PLAIN,      8'h80,   1'b0, 4'd1, 72'h80};
        dir_table[4]  = '{CFG_CARET,      8'h00,   1'b0, 4'd2, "^@"};
        dir_table[5]  = '{CFG_CARET,      8'h1F,   1'b0, 4'd2, "^_"};
        dir_table[6]  = '{CFG_CARET,      CH_DEL,  1'b0, 4'd2, "^?"};
        dir_table[7]  = '{CFG_CARET,      CH_NL,   1'b0, 4'd1, "\n"};
        dir_table[8]  = '{CFG_CARET_TABS, CH_TAB,  1'b0, 4'd2, "^I"};
        dir_table[9]  = '{CFG_ENDS,       CH_NL,   1'b0, 4'd2, "$\n"};
        dir_table[10] = '{CFG_NUM_ALL,    "a",     1'b1, 4'd8, "     1\ta"};
        dir_table[11] = '{CFG_NUM_ALL,    CH_NL,   1'b0, 4'd0, '0};
        dir_table[12] = '{CFG_NUM_ALL,    CH_NL,   1'b0, 4'd0, '0};
        dir_table[13] = '{CFG_NUM_TEXT,   CH_NL,   1'b0, 4'd0, '0};
        dir_table[14] = '{CFG_NUM_TEXT,   "b",     1'b0, 4'd0, '0};
        dir_table[15] = '{CFG_NUM_BOTH,   CH_NL,   1'b0, 4'd0, '0};
        dir_table[16] = '{CFG_NUM_BOTH,   CH_NL,   1'b0, 4'd0, '0};
        dir_table[17] = '{CFG_NUM_BOTH,   "c",     1'b0, 4'd0, '0};
        dir_table[18] = '{CFG_SQUEEZE,    CH_NL,   1'b0, 4'd0, '0};
        dir_table[19] = '{CFG_SQUEEZE,    CH_NL,   1'b0, 4'd0, '0};
        dir_table[20] = '{CFG_SQUEEZE,    CH_NL,   1'b0, 4'd0, '0};
        dir_table[21] = '{CFG_SQUEEZE,    "d",     1'b0, 4'd0, '0};
        dir_table[22] = '{CFG_ALL_ON,     CH_TAB,  1'b1, 4'd9, "     1\t^I"};
        dir_table[23] = '{CFG_ALL_ON,     8'hFF,   1'b0, 4'd1, 72'hFF};
        dir_table[24] = '{CFG_ALL_ON,     CH_NL,   1'b0, 4'd0, '0};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < NUM_DIRECTED; r++) begin
            if (r == 0 || dir_table[r].cfg != active_cfg)
                write_settings(dir_table[r].cfg);
            send_request(dir_table[r].raw, dir_table[r].new_file,
                         dir_table[r].exp_len, dir_table[r].exp_text);
        end

        // random text lines under changing settings
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: next_cfg = CFG_PLAIN;
                1: next_cfg = CFG_ALL_ON;
                2: next_cfg = '{2'd2, 1'b1, 1'b0, 1'b0, 1'b0};
                default: next_cfg = '{2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                                      1'($urandom), 1'($urandom)};
            endcase
            write_settings(next_cfg);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // hold off until the output side is empty
                if (phase == 3 && !mid_drained && sent >= PHASE_ITEMS / 2) begin
                    wait_drained();
                    mid_drained = 1'b1;
                end
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        n = $urandom_range(1, 4);
                        repeat (n) send_request(CH_NL, 1'b0, 0, '0);
                        sent += n;
                    end
                    9: begin
                        send_request(8'($urandom), 1'($urandom), 0, '0);
                        sent++;
                    end
                    default: begin
                        len = $urandom_range(1, 8);
                        send_request(pick_char(), $urandom_range(0, 15) == 0, 0, '0);
                        repeat (len - 1) send_request(pick_char(), 1'b0, 0, '0);
                        send_request(CH_NL, 1'b0, 0, '0);
                        sent += len + 1;
                    end
                endcase
            end
        end

        // numbered stretch so the counter carries into its third digit
        write_settings('{2'd1, 1'b0, 1'($urandom), 1'($urandom), 1'($urandom)});
        send_request(CH_NL, 1'b1, 0, '0);
        repeat (COUNT_LINES - 1) begin
            if ($urandom_range(0, 7) == 0)
                send_request(pick_char(), 1'b0, 0, '0);
            send_request(CH_NL, 1'b0, 0, '0);
        end

        wait_drained();
        if (rendered_q.size() != 0) begin
            error_count++;
            $display("%0d expected bytes never arrived", rendered_q.size());
        end

        $display("Covered %0d requests, %0d output bytes checked, %0d register settings.",
                 requests_in, bytes_out, settings_used);
        $display("Line counter reached %0h; %0d errors.", peak_line_no, error_count);
        if (error_count == 0)
            $display("[text_line_number_escape_filter] OK");
        else
            $display("[text_line_number_escape_filter] ERROR");
        $finish;
    end

endmodule
